>>> rtl/segment_circle_intersect_top_macros.svh
// Assertion macros for the segment / circle intersection block.
// Needs clk in the scope of each use, and rst_n for SCI_ASSERT; no other dependencies.
`ifndef SEGMENT_CIRCLE_INTERSECT_TOP_MACROS_SVH
`define SEGMENT_CIRCLE_INTERSECT_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SCI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("segment circle intersect: check failed");
`define SCI_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("segment circle intersect: check failed in reset");
`else
`define SCI_ASSERT(lbl, prop)
`define SCI_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/sci_pkg.sv
// Shared types for the segment / circle intersection pipeline.
// No dependencies; used by every module of the block.
package sci_pkg;

    typedef struct packed {
        logic valid;
        logic miss;
    } sci_ctrl_t;

    typedef struct packed {
        logic hit;
        logic exit_root;
    } sci_flags_t;

    typedef enum logic [1:0] {
        FILL_EMPTY = 2'd0,
        FILL_ONE   = 2'd1,
        FILL_TWO   = 2'd2
    } fill_t;

endpackage

>>> rtl/sci_front.sv
// Front stages: differences, products, a/h/c sums, h*h and a*c, discriminant.
// Depends on sci_pkg.
module sci_front #(
    parameter int COORD_BITS = 16,
    localparam int CB = COORD_BITS,
    localparam int W  = 2 * COORD_BITS + 2,
    localparam int DW = 4 * COORD_BITS + 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic signed [CB-1:0]      start_x,
    input  logic signed [CB-1:0]      start_y,
    input  logic signed [CB-1:0]      end_x,
    input  logic signed [CB-1:0]      end_y,
    input  logic signed [CB-1:0]      centre_x,
    input  logic signed [CB-1:0]      centre_y,
    input  logic [CB-2:0]             circle_radius,
    output sci_pkg::sci_ctrl_t        ctrl_out,
    output logic signed [DW-1:0]      disc_out,
    output logic [W-1:0]              a_out,
    output logic signed [W-1:0]       h_out
);

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [CB:0]    dx_reg, dy_reg, fx_reg, fy_reg;
    logic [CB-2:0]         r_reg;
    logic signed [W-1:0]   p_dxdx_reg, p_dydy_reg, p_fxdx_reg, p_fydy_reg;
    logic signed [W-1:0]   p_fxfx_reg, p_fyfy_reg;
    logic [W-1:0]          p_rr_reg;
    logic signed [W-1:0]   a3_reg, h3_reg, c3_reg;
    logic signed [W-1:0]   a4_reg, h4_reg;
    logic signed [2*W-1:0] hh_reg, ac_reg;
    logic signed [DW-1:0]  disc_next;
    sci_pkg::sci_ctrl_t    ctrl_reg;
    logic signed [DW-1:0]  disc_reg;
    logic [W-1:0]          a5_reg;
    logic signed [W-1:0]   h5_reg;

    assign disc_next = DW'(hh_reg) - DW'(ac_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            v1_reg         <= in_valid;
            v2_reg         <= v1_reg;
            v3_reg         <= v2_reg;
            v4_reg         <= v3_reg;
            ctrl_reg.valid <= v4_reg;
            ctrl_reg.miss  <= (a4_reg == '0) || disc_next[DW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= (CB+1)'(end_x) - (CB+1)'(start_x);
            dy_reg     <= (CB+1)'(end_y) - (CB+1)'(start_y);
            fx_reg     <= (CB+1)'(start_x) - (CB+1)'(centre_x);
            fy_reg     <= (CB+1)'(start_y) - (CB+1)'(centre_y);
            r_reg      <= circle_radius;
            p_dxdx_reg <= W'(dx_reg) * W'(dx_reg);
            p_dydy_reg <= W'(dy_reg) * W'(dy_reg);
            p_fxdx_reg <= W'(fx_reg) * W'(dx_reg);
            p_fydy_reg <= W'(fy_reg) * W'(dy_reg);
            p_fxfx_reg <= W'(fx_reg) * W'(fx_reg);
            p_fyfy_reg <= W'(fy_reg) * W'(fy_reg);
            p_rr_reg   <= W'(r_reg) * W'(r_reg);
            a3_reg     <= p_dxdx_reg + p_dydy_reg;
            h3_reg     <= p_fxdx_reg + p_fydy_reg;
            c3_reg     <= p_fxfx_reg + p_fyfy_reg - $signed(p_rr_reg);
            a4_reg     <= a3_reg;
            h4_reg     <= h3_reg;
            hh_reg     <= (2*W)'(h3_reg) * (2*W)'(h3_reg);
            ac_reg     <= (2*W)'(a3_reg) * (2*W)'(c3_reg);
            disc_reg   <= disc_next;
            a5_reg     <= $unsigned(a4_reg);
            h5_reg     <= h4_reg;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign disc_out = disc_reg;
    assign a_out    = a5_reg;
    assign h_out    = h5_reg;

endmodule

>>> rtl/sci_sqrt.sv
// Pipelined restoring square root of disc * 2^(2F), one root bit per stage.
// Depends on sci_pkg.
module sci_sqrt #(
    parameter int COORD_BITS = 16,
    parameter int PARAM_FRAC_BITS = 16,
    localparam int W   = 2 * COORD_BITS + 2,
    localparam int DW  = 4 * COORD_BITS + 5,
    localparam int RW  = 2 * COORD_BITS + 2 + PARAM_FRAC_BITS,
    localparam int RMW = RW + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  sci_pkg::sci_ctrl_t   ctrl_in,
    input  logic signed [DW-1:0] disc_in,
    input  logic [W-1:0]         a_in,
    input  logic signed [W-1:0]  h_in,
    output sci_pkg::sci_ctrl_t   ctrl_out,
    output logic [RW-1:0]        root_out,
    output logic                 rem_nz,
    output logic [W-1:0]         a_out,
    output logic signed [W-1:0]  h_out
);

    sci_pkg::sci_ctrl_t  ctrl_reg [RW];
    logic [RMW-1:0]      rem_reg  [RW];
    logic [RW-1:0]       root_reg [RW];
    logic [DW-1:0]       disc_reg [RW-1];
    logic [W-1:0]        a_reg    [RW];
    logic signed [W-1:0] h_reg    [RW];

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        localparam int P = RW - 1 - i;
        sci_pkg::sci_ctrl_t  ctrl_src;
        logic [RMW-1:0]      rem_src;
        logic [RW-1:0]       root_src;
        logic [DW-1:0]       disc_src;
        logic [W-1:0]        a_src;
        logic signed [W-1:0] h_src;
        logic [1:0]          pair;
        logic [RMW-1:0]      rem_sh, trial, rem_next;
        logic                ge;

        if (i == 0)
        begin : g_first
            assign ctrl_src = ctrl_in;
            assign rem_src  = '0;
            assign root_src = '0;
            assign disc_src = disc_in;
            assign a_src    = a_in;
            assign h_src    = h_in;
        end
        else
        begin : g_next
            assign ctrl_src = ctrl_reg[i-1];
            assign rem_src  = rem_reg[i-1];
            assign root_src = root_reg[i-1];
            assign disc_src = disc_reg[i-1];
            assign a_src    = a_reg[i-1];
            assign h_src    = h_reg[i-1];
        end

        if (2 * P >= 2 * PARAM_FRAC_BITS)
        begin : g_data
            assign pair = disc_src[2*P-2*PARAM_FRAC_BITS+1 : 2*P-2*PARAM_FRAC_BITS];
        end
        else
        begin : g_zero
            assign pair = 2'b00;
        end

        always_comb
        begin
            rem_sh   = {rem_src[RMW-3:0], pair};
            trial    = {root_src, 2'b01};
            ge       = rem_sh >= trial;
            rem_next = ge ? rem_sh - trial : rem_sh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctrl_reg[i] <= '0;
            end
            else if (en)
            begin
                ctrl_reg[i] <= ctrl_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= {root_src[RW-2:0], ge};
                a_reg[i]    <= a_src;
                h_reg[i]    <= h_src;
            end
        end

        if (i < RW - 1)
        begin : g_disc
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    disc_reg[i] <= disc_src;
                end
            end
        end
    end

    assign ctrl_out = ctrl_reg[RW-1];
    assign root_out = root_reg[RW-1];
    assign rem_nz   = |rem_reg[RW-1];
    assign a_out    = a_reg[RW-1];
    assign h_out    = h_reg[RW-1];

endmodule

>>> rtl/sci_select.sv
// Root selection: numerators and range checks in two stages.
// Depends on sci_pkg.
module sci_select #(
    parameter int COORD_BITS = 16,
    parameter int PARAM_FRAC_BITS = 16,
    localparam int W   = 2 * COORD_BITS + 2,
    localparam int RW  = 2 * COORD_BITS + 2 + PARAM_FRAC_BITS,
    localparam int NW  = 2 * COORD_BITS + 5 + PARAM_FRAC_BITS,
    localparam int NDW = W + PARAM_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  sci_pkg::sci_ctrl_t   ctrl_in,
    input  logic [RW-1:0]        root_in,
    input  logic                 rem_nz,
    input  logic [W-1:0]         a_in,
    input  logic signed [W-1:0]  h_in,
    output logic                 valid_out,
    output sci_pkg::sci_flags_t  flags_out,
    output logic [NDW-1:0]       num_out,
    output logic [W-1:0]         a_out
);

    localparam int F = PARAM_FRAC_BITS;

    logic signed [NW-1:0] x, fl, ce;
    sci_pkg::sci_ctrl_t   ctrl_reg;
    logic signed [NW-1:0] n1_reg, t1_reg, n2_reg, t2_reg, lim_reg;
    logic [W-1:0]         a1_reg;
    logic                 take1, take2;
    logic                 valid_reg;
    sci_pkg::sci_flags_t  flags_reg;
    logic [NDW-1:0]       num_reg;
    logic [W-1:0]         a2_reg;

    always_comb
    begin
        x  = (-NW'(h_in)) <<< F;
        fl = $signed(NW'(root_in));
        ce = fl + $signed(NW'(rem_nz));
    end

    always_comb
    begin
        take1 = !ctrl_reg.miss && !n1_reg[NW-1] && (t1_reg <= lim_reg);
        take2 = !ctrl_reg.miss && !take1 && !n2_reg[NW-1] && (t2_reg <= lim_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            ctrl_reg  <= ctrl_in;
            valid_reg <= ctrl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg              <= x - ce;
            t1_reg              <= x - fl;
            n2_reg              <= x + fl;
            t2_reg              <= x + ce;
            lim_reg             <= $signed(NW'(a_in)) <<< F;
            a1_reg              <= a_in;
            flags_reg.hit       <= take1 || take2;
            flags_reg.exit_root <= take2;
            num_reg             <= take1 ? NDW'(n1_reg) : NDW'(n2_reg);
            a2_reg              <= a1_reg;
        end
    end

    assign valid_out = valid_reg;
    assign flags_out = flags_reg;
    assign num_out   = num_reg;
    assign a_out     = a2_reg;

endmodule

>>> rtl/sci_div.sv
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Depends on sci_pkg.
module sci_div #(
    parameter int COORD_BITS = 16,
    parameter int PARAM_FRAC_BITS = 16,
    localparam int W   = 2 * COORD_BITS + 2,
    localparam int F   = PARAM_FRAC_BITS,
    localparam int NDW = W + PARAM_FRAC_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                valid_in,
    input  sci_pkg::sci_flags_t flags_in,
    input  logic [NDW-1:0]      num_in,
    input  logic [W-1:0]        a_in,
    output logic                valid_out,
    output sci_pkg::sci_flags_t flags_out,
    output logic [F:0]          quot_out
);

    logic                valid_reg [F+1];
    sci_pkg::sci_flags_t flags_reg [F+1];
    logic [F:0]          q_reg     [F+1];
    logic [NDW-1:0]      rem_reg   [F];
    logic [W-1:0]        a_reg     [F];

    for (genvar i = 0; i <= F; i++)
    begin : g_stage
        localparam int B = F - i;
        logic                valid_src;
        sci_pkg::sci_flags_t flags_src;
        logic [F:0]          q_src;
        logic [NDW-1:0]      rem_src, a_sh;
        logic [W-1:0]        a_src;
        logic                ge;

        if (i == 0)
        begin : g_first
            assign valid_src = valid_in;
            assign flags_src = flags_in;
            assign q_src     = '0;
            assign rem_src   = num_in;
            assign a_src     = a_in;
        end
        else
        begin : g_next
            assign valid_src = valid_reg[i-1];
            assign flags_src = flags_reg[i-1];
            assign q_src     = q_reg[i-1];
            assign rem_src   = rem_reg[i-1];
            assign a_src     = a_reg[i-1];
        end

        assign a_sh = NDW'(a_src) << B;
        assign ge   = rem_src >= a_sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flags_reg[i] <= flags_src;
                q_reg[i]     <= q_src | ((F+1)'(ge) << B);
            end
        end

        if (i < F)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= ge ? rem_src - a_sh : rem_src;
                    a_reg[i]   <= a_src;
                end
            end
        end
    end

    assign valid_out = valid_reg[F];
    assign flags_out = flags_reg[F];
    assign quot_out  = q_reg[F];

endmodule

>>> rtl/segment_circle_intersect_top.sv
// Segment / circle intersection, fully pipelined: one word accepted per cycle.
// Stages: five front stages, one per root bit of the square root, two select stages,
// one per quotient bit, one output register. A two-word output buffer lets input flow
// while one result waits; the pipeline holds only when both buffer entries are full.
// rst_n clears all valid bits.
// Depends on sci_pkg, sci_front, sci_sqrt, sci_select, sci_div and the macro header.
`include "segment_circle_intersect_top_macros.svh"
module segment_circle_intersect_top #(
    parameter int COORD_BITS = 16,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // start_x, start_y, end_x, end_y, centre_x, centre_y, circle_radius
    input  logic [((7*COORD_BITS+6)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // hit, hit_param, exit_root
    output logic [((PARAM_FRAC_BITS+10)/8)*8-1:0] m_tdata
);

    localparam int CB    = COORD_BITS;
    localparam int F     = PARAM_FRAC_BITS;
    localparam int W     = 2 * CB + 2;
    localparam int DW    = 4 * CB + 5;
    localparam int RW    = 2 * CB + 2 + F;
    localparam int NDW   = W + F;
    localparam int OUT_W = F + 3;
    localparam int TDW   = ((F + 10) / 8) * 8;

    logic                en;
    sci_pkg::sci_ctrl_t  fr_ctrl, sq_ctrl;
    logic signed [DW-1:0] fr_disc;
    logic [W-1:0]        fr_a, sq_a, se_a;
    logic signed [W-1:0] fr_h, sq_h;
    logic [RW-1:0]       sq_root;
    logic                sq_rem_nz;
    logic                se_valid, dv_valid;
    sci_pkg::sci_flags_t se_flags, dv_flags;
    logic [NDW-1:0]      se_num;
    logic [F:0]          dv_quot;
    logic [OUT_W-1:0]    new_word;
    logic                push, pop;
    sci_pkg::fill_t      fill_reg, fill_next;
    logic [OUT_W-1:0]    head_reg, head_next, tail_reg, tail_next;

    assign en       = (fill_reg != sci_pkg::FILL_TWO);
    assign s_tready = en;

    sci_front #(.COORD_BITS(CB)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_tvalid),
        .start_x       (s_tdata[CB-1:0]),
        .start_y       (s_tdata[2*CB-1:CB]),
        .end_x         (s_tdata[3*CB-1:2*CB]),
        .end_y         (s_tdata[4*CB-1:3*CB]),
        .centre_x      (s_tdata[5*CB-1:4*CB]),
        .centre_y      (s_tdata[6*CB-1:5*CB]),
        .circle_radius (s_tdata[7*CB-2:6*CB]),
        .ctrl_out      (fr_ctrl),
        .disc_out      (fr_disc),
        .a_out         (fr_a),
        .h_out         (fr_h)
    );

    sci_sqrt #(.COORD_BITS(CB), .PARAM_FRAC_BITS(F)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctrl_in  (fr_ctrl),
        .disc_in  (fr_disc),
        .a_in     (fr_a),
        .h_in     (fr_h),
        .ctrl_out (sq_ctrl),
        .root_out (sq_root),
        .rem_nz   (sq_rem_nz),
        .a_out    (sq_a),
        .h_out    (sq_h)
    );

    sci_select #(.COORD_BITS(CB), .PARAM_FRAC_BITS(F)) u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .ctrl_in   (sq_ctrl),
        .root_in   (sq_root),
        .rem_nz    (sq_rem_nz),
        .a_in      (sq_a),
        .h_in      (sq_h),
        .valid_out (se_valid),
        .flags_out (se_flags),
        .num_out   (se_num),
        .a_out     (se_a)
    );

    sci_div #(.COORD_BITS(CB), .PARAM_FRAC_BITS(F)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (se_valid),
        .flags_in  (se_flags),
        .num_in    (se_num),
        .a_in      (se_a),
        .valid_out (dv_valid),
        .flags_out (dv_flags),
        .quot_out  (dv_quot)
    );

    assign new_word = {dv_flags.exit_root, dv_flags.hit ? dv_quot : (F+1)'(0), dv_flags.hit};
    assign push     = en && dv_valid;
    assign m_tvalid = (fill_reg != sci_pkg::FILL_EMPTY);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = TDW'(head_reg);

    always_comb
    begin
        fill_next = fill_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        unique case (fill_reg)
            sci_pkg::FILL_EMPTY:
            begin
                if (push)
                begin
                    head_next = new_word;
                    fill_next = sci_pkg::FILL_ONE;
                end
            end
            sci_pkg::FILL_ONE:
            begin
                if (push && pop)
                begin
                    head_next = new_word;
                end
                else if (push)
                begin
                    tail_next = new_word;
                    fill_next = sci_pkg::FILL_TWO;
                end
                else if (pop)
                begin
                    fill_next = sci_pkg::FILL_EMPTY;
                end
            end
            sci_pkg::FILL_TWO:
            begin
                if (pop)
                begin
                    head_next = tail_reg;
                    fill_next = sci_pkg::FILL_ONE;
                end
            end
            default:
            begin
                fill_next = sci_pkg::FILL_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= sci_pkg::FILL_EMPTY;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    `SCI_ASSERT(a_miss_zero, m_tvalid && !m_tdata[0] |-> m_tdata[OUT_W-1:1] == '0)
    `SCI_ASSERT(a_exit_hit, m_tvalid && m_tdata[OUT_W-1] |-> m_tdata[0])
    `SCI_ASSERT(a_param_range, m_tvalid |-> !(m_tdata[F+1] && (|m_tdata[F:1])))
    `SCI_ASSERT(a_stall_hold, !en |=> $stable(dv_valid) && $stable(dv_quot))

endmodule

>>> tb/tb_segment_circle_intersect_top.sv
// Testbench for segment_circle_intersect_top: streams segment/circle queries,
// predicts each hit, parameter and root flag with exact wide integer arithmetic.
// Depends only on the RTL of the block.
module tb_segment_circle_intersect_top;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 120;
    localparam int N_RANDOM = 1280;

    typedef struct packed {
        logic [14:0] radius;
        logic [15:0] cy;
        logic [15:0] cx;
        logic [15:0] ey;
        logic [15:0] ex;
        logic [15:0] sy;
        logic [15:0] sx;
    } query_t;

    localparam int QW = $bits(query_t);

    typedef struct packed {
        logic        exit_root;
        logic [16:0] param;
        logic        hit;
    } crossing_t;

    typedef struct {
        query_t    q;
        logic      typed;
        crossing_t res;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // start_x, start_y, end_x, end_y, centre_x, centre_y, circle_radius, pad
    logic [111:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // hit, hit_param, exit_root, pad
    logic [23:0]  m_tdata;

    crossing_t pending_crossings[$];
    int        errors = 0;
    int        idle_mode = IDLE_NONE;
    bit        hold_off = 1'b0;
    int        quiet_cycles = 0;

    segment_circle_intersect_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #1 clk = ~clk;

    function automatic crossing_t intersect_result(query_t q);
        longint sx, sy, ex, ey, cx, cy, r, dx, dy, fx, fy;
        logic signed [255:0] wa, wh, wc, disc, v, fl, ce, x, lim, n1, n2, cand, scale, qv;
        crossing_t res;
        sx = $signed(q.sx); sy = $signed(q.sy);
        ex = $signed(q.ex); ey = $signed(q.ey);
        cx = $signed(q.cx); cy = $signed(q.cy);
        r = q.radius;
        dx = ex - sx; dy = ey - sy;
        fx = sx - cx; fy = sy - cy;
        wa = dx * dx + dy * dy;
        wh = fx * dx + fy * dy;
        wc = fx * fx + fy * fy - r * r;
        res = '0;
        if (wa > 0)
        begin
            disc = wh * wh - wa * wc;
            if (disc >= 0)
            begin
                scale = 65536;
                v = disc * scale * scale;
                fl = 0;
                for (int b = 63; b >= 0; b--)
                begin
                    cand = fl | (256'sd1 << b);
                    if (cand * cand <= v)
                        fl = cand;
                end
                ce = (fl * fl == v) ? fl : fl + 1;
                x = -wh * scale;
                lim = wa * scale;
                n1 = x - ce;
                n2 = x + fl;
                if (n1 >= 0 && x - fl <= lim)
                begin
                    res.hit = 1'b1;
                end
                else if (n2 >= 0 && x + ce <= lim)
                begin
                    res.hit = 1'b1;
                    res.exit_root = 1'b1;
                    n1 = n2;
                end
                if (res.hit)
                begin
                    qv = 0;
                    for (int b = 16; b >= 0; b--)
                    begin
                        cand = qv | (256'sd1 << b);
                        if (cand * wa <= n1)
                            qv = cand;
                    end
                    res.param = qv[16:0];
                end
            end
        end
        return res;
    endfunction

    function automatic query_t mk(int sx, int sy, int ex, int ey, int cx, int cy, int r);
        query_t q;
        q.sx = sx[15:0]; q.sy = sy[15:0]; q.ex = ex[15:0]; q.ey = ey[15:0];
        q.cx = cx[15:0]; q.cy = cy[15:0]; q.radius = r[14:0];
        return q;
    endfunction

    function automatic int jitter(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic query_t random_query();
        query_t q;
        int cx, cy, r, k;
        k = $urandom_range(0, 9);
        if (k < 2)
        begin
            q = QW'({$urandom, $urandom, $urandom, $urandom});
        end
        else if (k < 4)
        begin
            q = mk(jitter(8), jitter(8), jitter(8), jitter(8), jitter(8), jitter(8),
                   $urandom_range(0, 8));
        end
        else if (k == 4)
        begin
            q = mk(jitter(1) ? 32767 : -32768, jitter(1) ? 32767 : -32768,
                   jitter(1) ? 32767 : -32768, jitter(1) ? 32767 : -32768,
                   jitter(32768), jitter(32768), $urandom_range(30000, 32767));
        end
        else
        begin
            cx = jitter(20000);
            cy = jitter(20000);
            r = $urandom_range(1, 4000);
            q = mk(cx + jitter(2 * r), cy + jitter(2 * r), cx + jitter(2 * r),
                   cy + jitter(2 * r), cx, cy, r);
        end
        return q;
    endfunction

    task automatic send_query(query_t q);
        if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)
        begin
            while ($urandom_range(0, 99) < ((idle_mode == IDLE_BOTH) ? 11 : 61))
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, q};
        do
            @(posedge clk);
        while (!s_tready);
        pending_crossings.push_back(intersect_result(q));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_crossings.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
            m_tready <= ($urandom_range(0, 99) >= ((idle_mode == IDLE_BOTH) ? 11 : 61));
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        crossing_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[18:0];
            if (pending_crossings.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
            end
            else
            begin
                want = pending_crossings.pop_front();
                if (got.hit !== want.hit)
                begin
                    errors++;
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
                end
                if (got.param !== want.param)
                begin
                    errors++;
                    $display("%0t: hit_param expected %0d actual %0d",
                             $time, want.param, got.param);
                end
                if (got.exit_root !== want.exit_root)
                begin
                    errors++;
                    $display("%0t: exit_root expected %0d actual %0d",
                             $time, want.exit_root, got.exit_root);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        row_t rows[$];
        crossing_t first;
        rows.push_back('{mk(5, 5, 5, 5, 0, 0, 100), 1'b1, '0});
        rows.push_back('{mk(0, 0, 10, 0, 0, 0, 5), 1'b1, '{1'b1, 17'd32768, 1'b1}});
        rows.push_back('{mk(-10, 0, 10, 0, 0, 0, 5), 1'b1, '{1'b0, 17'd16384, 1'b1}});
        rows.push_back('{mk(0, 0, 10, 0, 20, 0, 10), 1'b1, '{1'b0, 17'd65536, 1'b1}});
        rows.push_back('{mk(-1, 0, 1, 0, 0, 0, 5), 1'b1, '0});
        rows.push_back('{mk(0, 10, 1, 10, 0, 0, 5), 1'b1, '0});
        rows.push_back('{mk(5, 0, 20, 0, 0, 0, 5), 1'b1, '{1'b1, 17'd0, 1'b1}});
        rows.push_back('{mk(-10, 5, 10, 5, 0, 0, 5), 1'b0, '0});
        rows.push_back('{mk(-32768, -32768, 32767, 32767, 0, 0, 32767), 1'b0, '0});
        rows.push_back('{mk(32767, 32767, -32768, -32768, -32768, 32767, 32767), 1'b0, '0});
        rows.push_back('{mk(-32768, 32767, 32767, -32768, 32767, 32767, 0), 1'b0, '0});
        rows.push_back('{mk(-32768, -32768, -32768, -32767, -32768, -32768, 0), 1'b0, '0});
        rows.push_back('{mk(0, 0, 3, 4, 6, 8, 5), 1'b0, '0});
        rows.push_back('{mk(-32768, 0, 32767, 0, 0, 0, 1), 1'b0, '0});
        rows.push_back('{mk(100, 100, 100, 101, 100, 99, 0), 1'b0, '0});
        rows.push_back('{mk(0, 0, 0, 0, -32768, -32768, 0), 1'b1, '0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].typed)
            begin
                first = intersect_result(rows[i].q);
                if (first !== rows[i].res)
                begin
                    errors++;
                    $display("%0t: table row %0d expected %h actual %h",
                             $time, i, rows[i].res, first);
                end
            end
            send_query(rows[i].q);
        end
        wait_drained();

        for (int phase = IDLE_NONE; phase <= IDLE_BOTH; phase++)
        begin
            idle_mode = phase;
            for (int n = 0; n < N_RANDOM / 4; n++)
            begin
                if (phase == IDLE_RECV && n == 20)
                begin
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (300) @(posedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                send_query(random_query());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_crossings.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
